[rtl/e2r_pkg.sv]
`default_nettype none
package e2r_pkg;

  // CORDIC working width: Q2.30 plus guard bits.
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam logic signed [CW-1:0] CORDIC_ONE_K = 34'sd652032874;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 33'sd536870912;
      1: t = 33'sd316933406;
      2: t = 33'sd167458907;
      3: t = 33'sd85004756;
      4: t = 33'sd42667331;
      5: t = 33'sd21354465;
      6: t = 33'sd10679838;
      7: t = 33'sd5340245;
      8: t = 33'sd2670163;
      9: t = 33'sd1335087;
      10: t = 33'sd667544;
      11: t = 33'sd333772;
      12: t = 33'sd166886;
      13: t = 33'sd83443;
      14: t = 33'sd41722;
      15: t = 33'sd20861;
      16: t = 33'sd10430;
      17: t = 33'sd5215;
      18: t = 33'sd2608;
      19: t = 33'sd1304;
      20: t = 33'sd652;
      21: t = 33'sd326;
      22: t = 33'sd163;
      23: t = 33'sd81;
      24: t = 33'sd41;
      25: t = 33'sd20;
      26: t = 33'sd10;
      27: t = 33'sd5;
      28: t = 33'sd3;
      29: t = 33'sd1;
      30: t = 33'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/e2r_sincos.sv]
`default_nettype none
// Pipelined sine and cosine of one binary angle; each CORDIC stage is registered.
module e2r_sincos #(
  parameter int ANGLE_BITS = 16,
  parameter int FRACTION_BITS = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [ANGLE_BITS-1:0]        ang,
  output logic signed [FRACTION_BITS+1:0]   sin_q,
  output logic signed [FRACTION_BITS+1:0]   cos_q
);

  localparam int CW = e2r_pkg::CW;
  localparam int ZW = e2r_pkg::ZW;
  localparam int OW = FRACTION_BITS + 2;
  localparam int SH = 30 - FRACTION_BITS;
  localparam int RS = (SH > 0) ? SH - 1 : 0;

  logic signed [CW-1:0] x [CORDIC_STAGES+1];
  logic signed [CW-1:0] y [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z [CORDIC_STAGES+1];
  logic [1:0]           q [CORDIC_STAGES+1];

  logic [31:0] a32;
  logic [1:0]  q0;
  logic [31:0] rr;

  // Quarter-turn split of the angle moved to 32 bits per turn.
  always_comb begin
    a32 = 32'(ang) << (32 - ANGLE_BITS);
    q0 = 2'((a32 + 32'h2000_0000) >> 30);
    rr = a32 - {q0, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= e2r_pkg::CORDIC_ONE_K;
      y[0] <= '0;
      z[0] <= ZW'(signed'(rr));
      q[0] <= q0;
    end
  end

  // Rotation stages; the shifts are arithmetic.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1] <= q[i];
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - e2r_pkg::atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + e2r_pkg::atan_turn(i);
        end
      end
    end
  end

  logic signed [CW-1:0] cr, sr;
  logic signed [CW-1:0] cres, sres;

  // With no bits to drop the value passes unrounded.
  function automatic logic signed [OW-1:0] rnd_sat(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (SH == 0) ? v : ((v + (CW'(1) <<< RS)) >>> SH);
    if (r > (CW'(1) <<< FRACTION_BITS)) return OW'(1) <<< FRACTION_BITS;
    if (r < -(CW'(1) <<< FRACTION_BITS)) return -(OW'(1) <<< FRACTION_BITS);
    return OW'(r);
  endfunction

  // Quarter-turn fold, rounding and saturation.
  always_comb begin
    case (q[CORDIC_STAGES])
      2'd0: begin cr = x[CORDIC_STAGES]; sr = y[CORDIC_STAGES]; end
      2'd1: begin cr = -y[CORDIC_STAGES]; sr = x[CORDIC_STAGES]; end
      2'd2: begin cr = -x[CORDIC_STAGES]; sr = -y[CORDIC_STAGES]; end
      default: begin cr = y[CORDIC_STAGES]; sr = -x[CORDIC_STAGES]; end
    endcase
    cres = cr;
    sres = sr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= rnd_sat(cres);
      sin_q <= rnd_sat(sres);
    end
  end

endmodule
`default_nettype wire

[rtl/e2r_matrix.sv]
`default_nettype none
// Three registered stages, products and then sums, forming the nine matrix entries.
module e2r_matrix #(
  parameter int FRACTION_BITS = 14
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [FRACTION_BITS+1:0] sp, cp, sy, cy, sr, cr,
  output logic signed [15:0]               m [9]
);

  localparam int OW = FRACTION_BITS + 2;
  localparam int PW = 2 * OW;
  localparam int SW = OW + 2;

  function automatic logic signed [OW:0] mulr(input logic signed [OW-1:0] a,
                                               input logic signed [OW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    p = (p + (PW'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    return (OW + 1)'(p);
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v > (SW'(1) <<< FRACTION_BITS)) r = SW'(1) <<< FRACTION_BITS;
    if (v < -(SW'(1) <<< FRACTION_BITS)) r = -(SW'(1) <<< FRACTION_BITS);
    return 16'(r);
  endfunction

  // Stage A: roll times sin pitch, plus delayed factors.
  logic signed [OW-1:0] a_sp, a_cp, a_sy, a_cy, a_sr, a_cr;
  logic signed [OW:0]   a_srsp, a_crsp;
  always_ff @(posedge clk) begin
    if (en) begin
      a_srsp <= mulr(sr, sp);
      a_crsp <= mulr(cr, sp);
      a_sp <= sp; a_cp <= cp; a_sy <= sy; a_cy <= cy; a_sr <= sr; a_cr <= cr;
    end
  end

  // Stage B: remaining products, including the three-factor terms; rounded products stay in range.
  logic signed [OW:0] b_p [12];
  logic signed [OW-1:0] b_sp;
  always_ff @(posedge clk) begin
    if (en) begin
      b_p[0]  <= mulr(a_cp, a_cy);
      b_p[1]  <= mulr(a_cp, a_sy);
      b_p[2]  <= mulr(OW'(a_srsp), a_cy);
      b_p[3]  <= mulr(a_cr, a_sy);
      b_p[4]  <= mulr(OW'(a_srsp), a_sy);
      b_p[5]  <= mulr(a_cr, a_cy);
      b_p[6]  <= mulr(a_sr, a_cp);
      b_p[7]  <= mulr(OW'(a_crsp), a_cy);
      b_p[8]  <= mulr(a_sr, a_sy);
      b_p[9]  <= mulr(OW'(a_crsp), a_sy);
      b_p[10] <= mulr(a_sr, a_cy);
      b_p[11] <= mulr(a_cr, a_cp);
      b_sp    <= a_sp;
    end
  end

  // Stage C: exact sums and saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= sat(SW'(b_p[0]));
      m[1] <= sat(SW'(b_p[1]));
      m[2] <= sat(-SW'(b_sp));
      m[3] <= sat(SW'(b_p[2]) - SW'(b_p[3]));
      m[4] <= sat(SW'(b_p[4]) + SW'(b_p[5]));
      m[5] <= sat(SW'(b_p[6]));
      m[6] <= sat(SW'(b_p[7]) + SW'(b_p[8]));
      m[7] <= sat(SW'(b_p[9]) - SW'(b_p[10]));
      m[8] <= sat(SW'(b_p[11]));
    end
  end

endmodule
`default_nettype wire

[rtl/euler_to_rotation_matrix_core.sv]
`default_nettype none
// Rotation matrix from pitch, yaw and roll binary angles (2^ANGLE_BITS per
// turn), nine signed Q1.FRACTION_BITS entries saturated to +-1. The block is a
// stall-able pipeline that accepts one transaction per cycle while not stalled;
// its registered steps are the input fold, the CORDIC stages, fold and
// rounding, then three product and sum stages. The whole pipeline advances
// whenever its last stage is empty or being taken.
module euler_to_rotation_matrix_core #(
  parameter int ANGLE_BITS = 16,
  parameter int FRACTION_BITS = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] pitch,
  input  wire logic [15:0] yaw,
  input  wire logic [15:0] roll,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2
);

  localparam int LAT = CORDIC_STAGES + 5;
  localparam int OW = FRACTION_BITS + 2;

  logic en;
  logic [LAT-1:0] vld;

  assign en = !vld[LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [OW-1:0] sp, cp, sy, cy, sr, cr;
  logic signed [15:0] m [9];

  e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)) u_p (.clk(clk), .en(en),
    .ang(ANGLE_BITS'(pitch)), .sin_q(sp), .cos_q(cp));
  e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)) u_y (.clk(clk), .en(en),
    .ang(ANGLE_BITS'(yaw)), .sin_q(sy), .cos_q(cy));
  e2r_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)) u_r (.clk(clk), .en(en),
    .ang(ANGLE_BITS'(roll)), .sin_q(sr), .cos_q(cr));

  e2r_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_m (.clk(clk), .en(en),
    .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr), .m(m));

  assign r0c0 = m[0];
  assign r1c0 = m[1];
  assign r2c0 = m[2];
  assign r0c1 = m[3];
  assign r1c1 = m[4];
  assign r2c1 = m[5];
  assign r0c2 = m[6];
  assign r1c2 = m[7];
  assign r2c2 = m[8];

  // A stalled result holds its valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // Input is refused only while the output stalls.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready) else $error("spurious stall");

endmodule
`default_nettype wire
